>>> rtl/ldcs_pkg.sv
// Shared types and constants for the LED driver command serializer.
// No dependencies; imported by every module of the block.
package ldcs_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 8;

  localparam logic [7:0] CMD_MODE     = 8'h44;
  localparam logic [7:0] CMD_ADDR     = 8'hC0;
  localparam logic [7:0] CMD_DISP_ON  = 8'h88;
  localparam logic [7:0] CMD_DISP_OFF = 8'h80;
  localparam logic [2:0] BOOT_LEVEL   = 3'h3;
  localparam logic [2:0] MAX_LEVEL    = 3'h7;

  localparam logic [1:0] OP_DIGIT  = 2'd0;
  localparam logic [1:0] OP_BRIGHT = 2'd1;
  localparam logic [1:0] OP_ON     = 2'd2;
  localparam logic [1:0] OP_OFF    = 2'd3;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_A    = 4'd1;
  localparam logic [3:0] PH_START_B    = 4'd2;
  localparam logic [3:0] PH_BIT_SET    = 4'd3;
  localparam logic [3:0] PH_BIT_CLK    = 4'd4;
  localparam logic [3:0] PH_ACK_LOW    = 4'd5;
  localparam logic [3:0] PH_ACK_HI_OK  = 4'd6;
  localparam logic [3:0] PH_ACK_HI_NAK = 4'd7;
  localparam logic [3:0] PH_STOP_A     = 4'd8;
  localparam logic [3:0] PH_STOP_B     = 4'd9;

  // one tick after decode: command bytes are prebuilt, enable checks are left to the back end
  typedef struct packed {
    logic       request;
    logic [1:0] op;
    logic       pos_ok;
    logic [7:0] first;
    logic [7:0] second;
    logic       two_bytes;
    logic       sample;
  } ldcs_item_t;

endpackage

>>> rtl/ldcs_front.sv
// Front end: unpacks input words, builds command bytes and queues the ticks.
// Depends on ldcs_pkg.
module ldcs_front #(
  parameter int DEPTH = ldcs_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [ldcs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [ldcs_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            item_valid,
  input  logic                            item_pop,
  output ldcs_pkg::ldcs_item_t            item
);
  import ldcs_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [2:0] DIGIT_LIMIT = 3'(DIGIT_COUNT);

  ldcs_item_t queue [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  ldcs_item_t       decoded;
  logic [2:0]       position;
  logic [7:0]       segments;
  logic [3:0]       level;
  logic [2:0]       level_sat;
  logic             push;

  assign position = s_axis_tdata[2:0];
  assign segments = s_axis_tdata[10:3];
  assign level    = s_axis_tdata[14:11];
  assign level_sat = (level > {1'b0, MAX_LEVEL}) ? MAX_LEVEL : level[2:0];

  always_comb begin
    decoded.request   = s_axis_tuser[0];
    decoded.op        = s_axis_tuser[2:1];
    decoded.pos_ok    = position < DIGIT_LIMIT;
    decoded.second    = segments;
    decoded.two_bytes = 1'b0;
    decoded.sample    = s_axis_tdata[15];
    unique case (decoded.op)
      OP_DIGIT: begin
        decoded.first     = CMD_ADDR | {5'b0, position};
        decoded.two_bytes = 1'b1;
      end
      OP_BRIGHT: decoded.first = CMD_DISP_ON | {5'b0, level_sat};
      OP_ON:     decoded.first = CMD_DISP_ON;
      default:   decoded.first = CMD_DISP_OFF;
    endcase
  end

  assign s_axis_tready = count != CNT_W'(DEPTH);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid    = count != '0;
  assign item          = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (item_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, item_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count overflow");
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> count != '0) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !item_pop) |=> count == $past(count) + 1'b1) else $error("push lost");

endmodule

>>> rtl/ldcs_back.sv
// Back end: pin waveform sequencer, one queued tick per step, with output register.
// Depends on ldcs_pkg.
module ldcs_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [7:0]                      cfg_wdata,
  input  logic                            item_valid,
  output logic                            item_pop,
  input  ldcs_pkg::ldcs_item_t            item,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ldcs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ldcs_pkg::*;

  logic [7:0] bit_delay;
  logic [3:0] phase, phase_next;
  logic [2:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] next_byte, next_byte_next;
  logic [1:0] bytes_left, bytes_left_next;
  logic       display_enabled, display_enabled_next;
  logic [7:0] delay_count, delay_count_next;
  logic [1:0] frames_left, frames_left_next;

  logic       pin_clk, pin_dio, pin_drive, busy, accepted, retrying;
  logic       bit_val;
  logic       start;
  logic [7:0] start_first, start_second;
  logic [1:0] start_count;
  logic [1:0] bytes_dec, frames_dec;

  assign item_pop = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign bit_val  = shift_byte[bit_index];
  assign bytes_dec  = (bytes_left != 2'd0) ? bytes_left - 2'd1 : 2'd0;
  assign frames_dec = (frames_left != 2'd0) ? frames_left - 2'd1 : 2'd0;

  always_comb begin
    pin_clk   = 1'b1;
    pin_dio   = 1'b1;
    pin_drive = 1'b1;
    busy      = 1'b1;
    accepted  = 1'b0;
    retrying  = 1'b0;
    unique case (phase)
      PH_IDLE:    busy = 1'b0;
      PH_START_A: ;
      PH_START_B: pin_dio = 1'b0;
      PH_BIT_SET: begin
        pin_clk = 1'b0;
        pin_dio = bit_val;
      end
      PH_BIT_CLK: pin_dio = bit_val;
      PH_ACK_LOW: begin
        pin_clk   = 1'b0;
        pin_dio   = 1'b0;
        pin_drive = 1'b0;
      end
      PH_ACK_HI_OK, PH_ACK_HI_NAK: begin
        pin_dio   = 1'b0;
        pin_drive = 1'b0;
      end
      PH_STOP_A: begin
        pin_clk = 1'b0;
        pin_dio = 1'b0;
      end
      PH_STOP_B: pin_dio = 1'b0;
      default:   busy = 1'b0;
    endcase

    phase_next           = phase;
    bit_index_next       = bit_index;
    shift_byte_next      = shift_byte;
    next_byte_next       = next_byte;
    bytes_left_next      = bytes_left;
    display_enabled_next = display_enabled;
    delay_count_next     = delay_count;
    frames_left_next     = frames_left;
    start        = 1'b0;
    start_first  = item.first;
    start_second = 8'h00;
    start_count  = 2'd1;

    if (phase == PH_IDLE) begin
      if (item.request) begin
        accepted = 1'b1;
        unique case (item.op)
          OP_DIGIT: begin
            start        = display_enabled && item.pos_ok;
            start_second = item.second;
            start_count  = item.two_bytes ? 2'd2 : 2'd1;
          end
          OP_BRIGHT: start = display_enabled;
          OP_ON: begin
            start = !display_enabled;
            if (!display_enabled) display_enabled_next = 1'b1;
          end
          default: begin
            start = display_enabled;
            if (display_enabled) display_enabled_next = 1'b0;
          end
        endcase
      end
    end else if (phase > PH_STOP_B) begin
      phase_next       = PH_IDLE;
      delay_count_next = 8'd0;
    end else if (delay_count != 8'd0) begin
      delay_count_next = delay_count - 8'd1;
    end else begin
      delay_count_next = bit_delay;
      unique case (phase)
        PH_START_A: phase_next = PH_START_B;
        PH_START_B: begin
          bit_index_next = 3'd0;
          phase_next     = PH_BIT_SET;
        end
        PH_BIT_SET: phase_next = PH_BIT_CLK;
        PH_BIT_CLK: begin
          bit_index_next = bit_index + 3'd1;
          phase_next     = (bit_index == 3'd7) ? PH_ACK_LOW : PH_BIT_SET;
        end
        PH_ACK_LOW: begin
          retrying   = item.sample;
          phase_next = item.sample ? PH_ACK_HI_NAK : PH_ACK_HI_OK;
        end
        PH_ACK_HI_NAK: begin
          bit_index_next = 3'd0;
          phase_next     = PH_BIT_SET;
        end
        PH_ACK_HI_OK: begin
          bytes_left_next = bytes_dec;
          if (bytes_dec != 2'd0) begin
            shift_byte_next = next_byte;
            bit_index_next  = 3'd0;
            phase_next      = PH_BIT_SET;
          end else begin
            phase_next = PH_STOP_A;
          end
        end
        PH_STOP_A: phase_next = PH_STOP_B;
        default: begin
          frames_left_next = frames_dec;
          if (frames_dec != 2'd0) begin
            start       = 1'b1;
            start_first = next_byte;
          end else begin
            phase_next       = PH_IDLE;
            delay_count_next = 8'd0;
          end
        end
      endcase
    end

    if (start) begin
      shift_byte_next  = start_first;
      next_byte_next   = start_second;
      bytes_left_next  = start_count;
      bit_index_next   = 3'd0;
      phase_next       = PH_START_A;
      delay_count_next = bit_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_delay <= 8'd0;
    end else if (cfg_wen) begin
      bit_delay <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START_A;
      bit_index       <= 3'd0;
      shift_byte      <= CMD_MODE;
      next_byte       <= CMD_DISP_ON | {5'b0, BOOT_LEVEL};
      bytes_left      <= 2'd1;
      display_enabled <= 1'b1;
      delay_count     <= 8'd0;
      frames_left     <= 2'd2;
    end else if (item_pop) begin
      phase           <= phase_next;
      bit_index       <= bit_index_next;
      shift_byte      <= shift_byte_next;
      next_byte       <= next_byte_next;
      bytes_left      <= bytes_left_next;
      display_enabled <= display_enabled_next;
      delay_count     <= delay_count_next;
      frames_left     <= frames_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (item_pop) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      m_axis_tdata <= {2'b00, retrying, accepted, busy, pin_drive, pin_dio, pin_clk};
    end
  end

  a_idle_no_delay: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> delay_count == 8'd0) else $error("idle with pending delay");
  a_bytes_in_flight: assert property (@(posedge clk) disable iff (rst)
    (phase >= PH_BIT_SET && phase <= PH_ACK_HI_NAK) |-> bytes_left != 2'd0)
    else $error("byte phase with no bytes left");
  a_retry_phase: assert property (@(posedge clk) disable iff (rst)
    (item_pop && retrying) |=> phase == PH_ACK_HI_NAK) else $error("retry not taken");

endmodule

>>> rtl/led_driver_command_serializer_top.sv
// Top level of the LED driver command serializer: front end queue plus waveform back end.
// Depends on ldcs_pkg, ldcs_front, ldcs_back.
//
// Each input word is one tick of a two-wire display waveform; each tick yields
// exactly one output word with the pin levels and status for that tick. The
// block sustains one word per clock on both sides while the queue is not full
// and the output is not stalled. A word passes through the queue and then the
// output register before its result handshake. The rate is set by the sequencer,
// which updates its state once per word. A queue of QUEUE_DEPTH words between
// front and back lets input and output stall independently. After reset the
// mode and display control frames play out as ticks arrive. The user must write
// bit_delay only while no word is in flight; the block itself does not enforce this.
module led_driver_command_serializer_top #(
  parameter int QUEUE_DEPTH = ldcs_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [7:0]                      cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // position[2:0], segments[10:3], level[14:11], dio_sample[15]
  input  logic [ldcs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // request[0], operation[2:1]
  input  logic [ldcs_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // clk_level[0], dio_level[1], dio_drive[2], busy_res[3], accepted[4], retrying[5]
  output logic [ldcs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import ldcs_pkg::*;

  ldcs_item_t item;
  logic       item_valid;
  logic       item_pop;

  ldcs_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (item_valid),
    .item_pop      (item_pop),
    .item          (item)
  );

  ldcs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .item_valid    (item_valid),
    .item_pop      (item_pop),
    .item          (item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
